// ===== hdl/lsa_pkg.sv =====
`default_nettype none
package lsa_pkg;

	localparam int SLOTS = 16;
	localparam int IDX_W = 4;
	localparam int CNT_W = 5;

	// actions
	localparam logic [1:0] ACT_LOAD    = 2'd0;
	localparam logic [1:0] ACT_SELECT  = 2'd1;
	localparam logic [1:0] ACT_RELEASE = 2'd2;

	// selection modes
	localparam logic [1:0] MODE_FIRST    = 2'd0;
	localparam logic [1:0] MODE_RANDOM   = 2'd1;
	localparam logic [1:0] MODE_ROUND    = 2'd2;
	localparam logic [1:0] MODE_WEIGHTED = 2'd3;

	// status codes
	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_NO_LINK   = 2'd1;
	localparam logic [1:0] ST_UNDERFLOW = 2'd2;

	// configuration register indexes
	localparam logic REG_MODE    = 1'b0;
	localparam logic REG_MIN_PRI = 1'b1;

	// shared unit operations
	localparam logic OP_DIV = 1'b0;
	localparam logic OP_MUL = 1'b1;

	localparam logic [63:0] WEIGHT_LIMIT = 64'h7FFF_FFFF_FFFF_FFFF;
	localparam logic [15:0] FLOW_MAX     = 16'hFFFF;

	typedef struct packed {
		logic        valid;
		logic [7:0]  prio;
		logic [7:0]  active;
		logic [7:0]  stalled;
		logic        blocked;
		logic [31:0] bandwidth;
		logic [15:0] flows;
	} slot_t;

	typedef struct packed {
		logic             we_full;
		logic             we_flows;
		logic [IDX_W-1:0] idx;
		slot_t            data;
	} slot_wr_t;

	typedef struct packed {
		logic        start;
		logic        op;
		logic [63:0] a;
		logic [31:0] b;
	} unit_req_t;

	typedef struct packed {
		logic        done;
		logic [63:0] res;
		logic [31:0] rem;
	} unit_rsp_t;

endpackage
`default_nettype wire

// ===== hdl/lsa_seq_unit.sv =====
`default_nettype none
// Shared bit-serial unit: 64/32 restoring divide (64 steps) or
// 64x32 shift-add multiply (32 steps).
module lsa_seq_unit (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire lsa_pkg::unit_req_t req,
	output lsa_pkg::unit_rsp_t     rsp
);

	logic        busy_q;
	logic        op_q;
	logic [6:0]  cnt_q;
	logic [63:0] a_q;
	logic [63:0] m_q;
	logic [31:0] b_q;
	logic [31:0] r_q;
	logic        done_q;

	logic [32:0] shifted;
	logic [32:0] trial;
	logic        ge;
	logic        last;

	always_comb begin
		shifted = {r_q, a_q[63]};
		trial   = shifted - {1'b0, b_q};
		ge      = (shifted >= {1'b0, b_q});
		last    = (op_q == lsa_pkg::OP_DIV) ? (cnt_q == 7'd63) : (cnt_q == 7'd31);
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 7'd1;
				if (last) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (req.start) begin
			op_q <= req.op;
			b_q  <= req.b;
			r_q  <= '0;
			if (req.op == lsa_pkg::OP_DIV) begin
				a_q <= req.a;
				m_q <= '0;
			end else begin
				a_q <= '0;
				m_q <= req.a;
			end
		end else if (busy_q) begin
			if (op_q == lsa_pkg::OP_DIV) begin
				a_q <= {a_q[62:0], ge};
				r_q <= ge ? trial[31:0] : shifted[31:0];
			end else begin
				a_q <= {a_q[62:0], 1'b0} + (b_q[31] ? m_q : 64'd0);
				b_q <= {b_q[30:0], 1'b0};
			end
		end
	end

	assign rsp.done = done_q;
	assign rsp.res  = a_q;
	assign rsp.rem  = r_q;

endmodule
`default_nettype wire

// ===== hdl/lsa_slot_table.sv =====
`default_nettype none
// Link table: one write port, one read port at a sequencer-chosen slot.
module lsa_slot_table (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire lsa_pkg::slot_wr_t         wr,
	input  wire logic [lsa_pkg::IDX_W-1:0] rd_idx,
	output lsa_pkg::slot_t                 rd
);

	logic        valid_q   [lsa_pkg::SLOTS];
	logic [15:0] flows_q   [lsa_pkg::SLOTS];
	logic [7:0]  prio_q    [lsa_pkg::SLOTS];
	logic [7:0]  active_q  [lsa_pkg::SLOTS];
	logic [7:0]  stalled_q [lsa_pkg::SLOTS];
	logic        blocked_q [lsa_pkg::SLOTS];
	logic [31:0] bw_q      [lsa_pkg::SLOTS];

	// valid marks and flow counts reset to zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < lsa_pkg::SLOTS; i++) begin
				valid_q[i] <= 1'b0;
				flows_q[i] <= '0;
			end
		end else if (wr.we_full) begin
			valid_q[wr.idx] <= wr.data.valid;
			flows_q[wr.idx] <= wr.data.flows;
		end else if (wr.we_flows) begin
			flows_q[wr.idx] <= wr.data.flows;
		end
	end

	// remaining fields, undefined until loaded
	always_ff @(posedge clk) begin
		if (wr.we_full) begin
			prio_q[wr.idx]    <= wr.data.prio;
			active_q[wr.idx]  <= wr.data.active;
			stalled_q[wr.idx] <= wr.data.stalled;
			blocked_q[wr.idx] <= wr.data.blocked;
			bw_q[wr.idx]      <= wr.data.bandwidth;
		end
	end

	always_comb begin
		rd.valid     = valid_q[rd_idx];
		rd.prio      = prio_q[rd_idx];
		rd.active    = active_q[rd_idx];
		rd.stalled   = stalled_q[rd_idx];
		rd.blocked   = blocked_q[rd_idx];
		rd.bandwidth = bw_q[rd_idx];
		rd.flows     = flows_q[rd_idx];
	end

endmodule
`default_nettype wire

// ===== hdl/link_selection_arbiter.sv =====
`default_nettype none
// Link selection arbiter.
// Command channel: an item is taken when start is high and busy is low.
// Each item gives one result, shown for one cycle with done high; the
// receiver cannot stall it. Configuration: cfg_valid/cfg_ready (always
// ready), cfg_index 0 = mode, 1 = minimum priority; write only when idle.
// Steps, start to done:
//   load writes the slot, release decrements its flow count, an unused action only answers.
//   select, first/random/round robin: a walk counting usable slots, a
//     modulo on the serial divider, then a search for the k-th usable
//     slot, then commit.
//   select, weighted: a walk over the 16 slots, a divide for the multiplier,
//     then per usable slot a 32-step multiply and 64-step divide on the same
//     shared unit, then commit.
// The serial divide/multiply unit is shared by these steps; one item is
// in flight at a time. busy drops in the cycle done is shown.
// Reset clears valid marks, flow counts, the round-robin counter and the
// registers; the other slot fields are undefined until loaded.
module link_selection_arbiter (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic [1:0]  action,
	input  wire logic [3:0]  entry_index,
	input  wire logic        entry_present,
	input  wire logic [7:0]  priority_in,
	input  wire logic [7:0]  active_in,
	input  wire logic [7:0]  stalled_in,
	input  wire logic        no_transmit_in,
	input  wire logic [31:0] bandwidth_in,
	input  wire logic [15:0] flows_in,
	input  wire logic [31:0] random_value,
	input  wire logic        commit,
	output logic             done,
	output logic             found,
	output logic [3:0]       chosen_index,
	output logic [1:0]       status,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic        cfg_index,
	input  wire logic [7:0]  cfg_data
);

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_REL  = 4'd1;
	localparam logic [3:0] S_P1   = 4'd2;
	localparam logic [3:0] S_KDIV = 4'd3;
	localparam logic [3:0] S_P2   = 4'd4;
	localparam logic [3:0] S_MDIV = 4'd5;
	localparam logic [3:0] S_WRD  = 4'd6;
	localparam logic [3:0] S_WMUL = 4'd7;
	localparam logic [3:0] S_WDIV = 4'd8;
	localparam logic [3:0] S_CMT  = 4'd9;

	localparam logic [lsa_pkg::IDX_W-1:0] LAST = lsa_pkg::IDX_W'(lsa_pkg::SLOTS - 1);

	logic [3:0]                state_q;
	logic [1:0]                mode_q;
	logic [7:0]                min_pri_q;
	logic [31:0]               turn_q;
	logic [lsa_pkg::IDX_W-1:0] ptr_q;
	logic [lsa_pkg::IDX_W-1:0] idx_q;
	logic [lsa_pkg::IDX_W-1:0] sel_q;
	logic [lsa_pkg::CNT_W-1:0] cnt_q;
	logic [lsa_pkg::CNT_W-1:0] k_q;
	logic [31:0]               key_q;
	logic                      commit_q;
	logic                      any_q;
	logic                      unk_q;
	logic                      first_q;
	logic [15:0]               best_flows_q;
	logic [31:0]               best_bw_q;
	logic [31:0]               max_bw_q;
	logic [62:0]               mult_q;
	logic [62:0]               best_score_q;
	logic                      done_q;
	logic                      found_q;
	logic [3:0]                chosen_q;
	logic [1:0]                status_q;

	lsa_pkg::slot_t            rd;
	lsa_pkg::slot_wr_t         wr;
	lsa_pkg::unit_req_t        ureq;
	lsa_pkg::unit_rsp_t        ursp;
	logic [lsa_pkg::IDX_W-1:0] rd_idx;

	logic                      use_ok;
	logic [lsa_pkg::CNT_W-1:0] cnt_nx;
	logic                      better;
	logic [62:0]               score;
	logic                      score_win;

	lsa_slot_table u_table (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (wr),
		.rd_idx (rd_idx),
		.rd     (rd)
	);

	lsa_seq_unit u_unit (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (ureq),
		.rsp    (ursp)
	);

	// read address
	always_comb begin
		unique case (state_q)
			S_REL:   rd_idx = idx_q;
			S_CMT:   rd_idx = sel_q;
			default: rd_idx = ptr_q;
		endcase
	end

	// slot evaluation
	always_comb begin
		use_ok = rd.valid && !rd.blocked && (rd.prio >= min_pri_q) &&
			((rd.active != 8'd0) || (rd.stalled == 8'd0));
		cnt_nx = cnt_q + lsa_pkg::CNT_W'(use_ok);
		better = !any_q || (rd.flows < best_flows_q) ||
			((rd.flows == best_flows_q) && (rd.bandwidth > best_bw_q));
		score     = ursp.res[62:0];
		score_win = first_q || (score > best_score_q) ||
			((score == best_score_q) && (rd.bandwidth > best_bw_q));
	end

	// shared unit requests
	always_comb begin
		ureq = '0;
		unique case (state_q)
			S_P1: begin
				if (ptr_q == LAST) begin
					if (mode_q != lsa_pkg::MODE_WEIGHTED) begin
						ureq.start = (cnt_nx != '0);
						ureq.op    = lsa_pkg::OP_DIV;
						ureq.a     = {32'd0, key_q};
						ureq.b     = 32'(cnt_nx);
					end else begin
						ureq.start = (any_q || use_ok) && !unk_q &&
							!(use_ok && rd.bandwidth == 32'd0);
						ureq.op    = lsa_pkg::OP_DIV;
						ureq.a     = lsa_pkg::WEIGHT_LIMIT;
						ureq.b     = (use_ok && rd.bandwidth > max_bw_q) ?
							rd.bandwidth : max_bw_q;
					end
				end
			end
			S_WRD: begin
				ureq.start = use_ok;
				ureq.op    = lsa_pkg::OP_MUL;
				ureq.a     = {1'b0, mult_q};
				ureq.b     = rd.bandwidth;
			end
			S_WMUL: begin
				ureq.start = ursp.done;
				ureq.op    = lsa_pkg::OP_DIV;
				ureq.a     = ursp.res;
				ureq.b     = 32'(rd.flows) + 32'd1;
			end
			default: ureq = '0;
		endcase
	end

	// table writes
	always_comb begin
		wr                = '0;
		wr.idx            = entry_index;
		wr.data.valid     = entry_present;
		wr.data.prio      = priority_in;
		wr.data.active    = active_in;
		wr.data.stalled   = stalled_in;
		wr.data.blocked   = no_transmit_in;
		wr.data.bandwidth = bandwidth_in;
		wr.data.flows     = flows_in;
		if (state_q == S_IDLE) begin
			wr.we_full = start && (action == lsa_pkg::ACT_LOAD);
		end else if (state_q == S_REL) begin
			wr.idx        = idx_q;
			wr.we_flows   = (rd.flows != 16'd0);
			wr.data.flows = rd.flows - 16'd1;
		end else if (state_q == S_CMT) begin
			wr.idx        = sel_q;
			wr.we_flows   = commit_q && (rd.flows != lsa_pkg::FLOW_MAX);
			wr.data.flows = rd.flows + 16'd1;
		end
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q    <= lsa_pkg::MODE_FIRST;
			min_pri_q <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				lsa_pkg::REG_MODE:    mode_q    <= cfg_data[1:0];
				lsa_pkg::REG_MIN_PRI: min_pri_q <= cfg_data;
				default:              ;
			endcase
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			turn_q   <= '0;
			done_q   <= 1'b0;
			found_q  <= 1'b0;
			chosen_q <= '0;
			status_q <= lsa_pkg::ST_OK;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						idx_q    <= entry_index;
						commit_q <= commit;
						ptr_q    <= '0;
						cnt_q    <= '0;
						any_q    <= 1'b0;
						unk_q    <= 1'b0;
						max_bw_q <= '0;
						found_q  <= 1'b0;
						chosen_q <= '0;
						status_q <= lsa_pkg::ST_OK;
						unique case (action)
							lsa_pkg::ACT_RELEASE: state_q <= S_REL;
							lsa_pkg::ACT_SELECT: begin
								state_q <= S_P1;
								unique case (mode_q)
									lsa_pkg::MODE_FIRST:  key_q <= '0;
									lsa_pkg::MODE_RANDOM: key_q <= random_value;
									lsa_pkg::MODE_ROUND: begin
										key_q  <= turn_q;
										turn_q <= turn_q + 32'd1;
									end
									default:              key_q <= '0;
								endcase
							end
							default: done_q <= 1'b1;
						endcase
					end
				end
				S_REL: begin
					if (rd.flows == 16'd0)
						status_q <= lsa_pkg::ST_UNDERFLOW;
					done_q  <= 1'b1;
					state_q <= S_IDLE;
				end
				S_P1: begin
					cnt_q <= cnt_nx;
					if (use_ok) begin
						any_q <= 1'b1;
						if (better) begin
							best_flows_q <= rd.flows;
							best_bw_q    <= rd.bandwidth;
							sel_q        <= ptr_q;
						end
						if (rd.bandwidth == 32'd0)
							unk_q <= 1'b1;
						if (rd.bandwidth > max_bw_q)
							max_bw_q <= rd.bandwidth;
					end
					ptr_q <= ptr_q + 1'b1;
					if (ptr_q == LAST) begin
						if (ureq.start) begin
							state_q <= (mode_q == lsa_pkg::MODE_WEIGHTED) ? S_MDIV : S_KDIV;
						end else if (mode_q == lsa_pkg::MODE_WEIGHTED && (any_q || use_ok)) begin
							state_q <= S_CMT;
						end else begin
							status_q <= lsa_pkg::ST_NO_LINK;
							done_q   <= 1'b1;
							state_q  <= S_IDLE;
						end
					end
				end
				S_KDIV: begin
					if (ursp.done) begin
						k_q     <= ursp.rem[lsa_pkg::CNT_W-1:0];
						cnt_q   <= '0;
						ptr_q   <= '0;
						state_q <= S_P2;
					end
				end
				S_P2: begin
					ptr_q <= ptr_q + 1'b1;
					if (use_ok) begin
						cnt_q <= cnt_nx;
						if (cnt_q == k_q) begin
							sel_q   <= ptr_q;
							state_q <= S_CMT;
						end
					end
				end
				S_MDIV: begin
					if (ursp.done) begin
						mult_q  <= ursp.res[62:0];
						ptr_q   <= '0;
						first_q <= 1'b1;
						state_q <= S_WRD;
					end
				end
				S_WRD: begin
					if (use_ok) begin
						state_q <= S_WMUL;
					end else if (ptr_q == LAST) begin
						state_q <= S_CMT;
					end else begin
						ptr_q <= ptr_q + 1'b1;
					end
				end
				S_WMUL: begin
					if (ursp.done)
						state_q <= S_WDIV;
				end
				S_WDIV: begin
					if (ursp.done) begin
						if (score_win) begin
							best_score_q <= score;
							best_bw_q    <= rd.bandwidth;
							sel_q        <= ptr_q;
						end
						first_q <= 1'b0;
						if (ptr_q == LAST) begin
							state_q <= S_CMT;
						end else begin
							ptr_q   <= ptr_q + 1'b1;
							state_q <= S_WRD;
						end
					end
				end
				S_CMT: begin
					found_q  <= 1'b1;
					chosen_q <= 4'(sel_q);
					done_q   <= 1'b1;
					state_q  <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign busy         = (state_q != S_IDLE);
	assign cfg_ready    = 1'b1;
	assign done         = done_q;
	assign found        = found_q;
	assign chosen_index = chosen_q;
	assign status       = status_q;

endmodule
`default_nettype wire

// ===== hdl/lsa_checker.sv =====
`default_nettype none
// Port-level checks on the result strobe.
module lsa_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       start,
	input wire logic       busy,
	input wire logic       done,
	input wire logic       found,
	input wire logic [3:0] chosen_index,
	input wire logic [1:0] status
);

	// a chosen link always reports ok
	a_found_ok: assert property (@(posedge clk) disable iff (!arst_n)
		done && found |-> status == lsa_pkg::ST_OK)
		else $error("found with non-ok status");

	// no choice reports slot zero
	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && !found |-> chosen_index == 4'd0)
		else $error("chosen index not zero without a link");

	// an accepted transaction is answered or still being worked
	a_accept: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy || done)
		else $error("transaction dropped");

endmodule

bind link_selection_arbiter lsa_checker u_lsa_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.start        (start),
	.busy         (busy),
	.done         (done),
	.found        (found),
	.chosen_index (chosen_index),
	.status       (status)
);
`default_nettype wire
